// File: rtl/retransmit_tracker_macros.svh
// assertion macros for the retransmit tracker
// expects clk and arst_n in the scope of use
`ifndef RETRANSMIT_TRACKER_MACROS_SVH
`define RETRANSMIT_TRACKER_MACROS_SVH

// condition must hold on every edge out of reset
`define RT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define RT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rt_pkg.sv
// types and constants shared by the retransmit tracker modules
// no dependencies
package rt_pkg;

	localparam int RT_DEPTH = 32;

	localparam logic [31:0] TIMEOUT_RST     = 32'd1000;
	localparam logic [7:0]  MAX_RETRIES_RST = 8'd5;

	typedef enum logic [1:0] {
		OP_RECORD  = 2'd0,
		OP_ACK     = 2'd1,
		OP_COLLECT = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_DONE     = 3'd0,
		EV_ACCEPTED = 3'd1,
		EV_REJECTED = 3'd2,
		EV_RESEND   = 3'd3,
		EV_DEAD     = 3'd4,
		EV_NONE     = 3'd5
	} event_t;

	typedef enum logic {
		REG_TIMEOUT     = 1'b0,
		REG_MAX_RETRIES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] seq_num;
		logic [15:0] payload_handle;
		logic [15:0] payload_len;
		logic [47:0] now_ms;
		logic [31:0] ack_num;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [31:0] out_seq;
		logic [15:0] out_handle;
		logic [15:0] out_len;
		logic [5:0]  pending_count;
		logic        last_flag;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] seq;
		logic [15:0] handle;
		logic [15:0] len;
		logic [47:0] now;
		logic [31:0] ack;
	} cmd_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [15:0] len;
		logic [47:0] sent;
		logic [7:0]  retries;
	} slot_t;

	typedef struct packed {
		event_t      kind;
		logic [31:0] seq;
		logic [15:0] handle;
		logic [15:0] len;
	} res_t;

endpackage

// File: rtl/rt_front.sv
// front end: two-entry input queue and opcode decode
// depends on rt_pkg
module rt_front import rt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t in_item,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);

	cmd_t       q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		dec.op     = op_t'(in_item.opcode);
		dec.seq    = in_item.seq_num;
		dec.handle = in_item.payload_handle;
		dec.len    = in_item.payload_len;
		dec.now    = in_item.now_ms;
		dec.ack    = in_item.ack_num;
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// File: rtl/rt_back.sv
// back end: slot table, ordered walk for ack and collect, result buffer
// depends on rt_pkg and retransmit_tracker_macros.svh
`include "retransmit_tracker_macros.svh"
module rt_back import rt_pkg::*; #(
	parameter int DEPTH = RT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic [31:0] timeout_ms,
	input  logic [7:0]  max_retries,
	output logic        empty,
	input  logic        pop,
	output out_item_t   out_item
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_TAIL,
		S_PREP,
		S_DRAIN
	} state_t;

	state_t         state_q;
	slot_t          slot_mem [DEPTH];
	res_t           res_mem  [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [31:0]    base_q;
	logic [AW-1:0]  base_slot_q;
	logic [CW-1:0]  count_q;
	cmd_t           cmd_q;
	logic [AW-1:0]  j_q;
	logic [AW-1:0]  ptr_q;
	logic           act_s1;
	logic           last_s1;
	logic [AW-1:0]  j_s1;
	logic [AW-1:0]  ptr_s1;
	slot_t          rd_s1;
	logic           found_q;
	logic [31:0]    nb_q;
	logic [AW-1:0]  nbs_q;
	logic [CW-1:0]  res_n_q;
	logic [AW-1:0]  rd_idx_q;
	res_t           res_rd_q;

	// record path
	logic [31:0]    diff;
	logic           rec_ok;
	logic [AW:0]    rec_sum;
	logic [AW-1:0]  rec_slot;
	// walk path
	logic [31:0]    s_cur;
	logic           v_cur;
	logic           is_ack;
	logic           due;
	logic           kill;
	logic           resend;
	logic           survive;
	logic           first_surv;
	logic           tail_push;
	// write ports
	logic           slot_we;
	logic [AW-1:0]  slot_wa;
	slot_t          slot_wd;
	logic           res_we;
	res_t           res_wd;
	logic           cmd_fire;
	logic           pop_fire;
	logic           rd_last;
	logic [AW-1:0]  rd_addr;

	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign empty     = (state_q != S_DRAIN);
	assign pop_fire  = pop && !empty;
	assign rd_last   = (CW'(rd_idx_q) == CW'(res_n_q - 1'b1));
	assign rd_addr   = pop_fire ? AW'(rd_idx_q + 1'b1) : rd_idx_q;

	// a sequence inside the window sits at its offset from the base slot
	always_comb begin
		diff     = cmd.seq - base_q;
		rec_ok   = (count_q == '0) || ((cmd.seq >= base_q) && (diff < 32'(DEPTH)));
		rec_sum  = {1'b0, base_slot_q} + {1'b0, diff[AW-1:0]};
		if (count_q == '0) begin
			rec_slot = base_slot_q;
		end else if (rec_sum >= DEPTH_W) begin
			rec_slot = AW'(rec_sum - DEPTH_W);
		end else begin
			rec_slot = rec_sum[AW-1:0];
		end
	end

	always_comb begin
		s_cur   = base_q + 32'(j_s1);
		v_cur   = act_s1 && valid_q[ptr_s1];
		is_ack  = (cmd_q.op == OP_ACK);
		due     = ((cmd_q.now - rd_s1.sent) >= {16'd0, timeout_ms});
		if (is_ack) begin
			kill = v_cur && (s_cur <= cmd_q.ack);
		end else begin
			kill = v_cur && due && (rd_s1.retries >= max_retries);
		end
		resend     = v_cur && !is_ack && due && !kill;
		survive    = v_cur && !kill;
		first_surv = survive && !found_q;
		tail_push  = act_s1 && last_s1 &&
			(is_ack || ((res_n_q == '0) && !resend && !kill));
	end

	always_comb begin
		slot_we = 1'b0;
		slot_wa = ptr_s1;
		slot_wd = '{handle: rd_s1.handle, len: rd_s1.len, sent: cmd_q.now,
			retries: rd_s1.retries + 8'd1};
		res_we  = 1'b0;
		res_wd  = '{kind: EV_DONE, seq: 32'd0, handle: 16'd0, len: 16'd0};
		if (cmd_fire) begin
			case (cmd.op)
				OP_RECORD: begin
					slot_we = rec_ok;
					slot_wa = rec_slot;
					slot_wd = '{handle: cmd.handle, len: cmd.len, sent: cmd.now,
						retries: 8'd0};
					res_we  = 1'b1;
					res_wd.kind = rec_ok ? EV_ACCEPTED : EV_REJECTED;
				end
				OP_QUERY: begin
					res_we = 1'b1;
				end
				default: ;
			endcase
		end else if (resend) begin
			slot_we = 1'b1;
			res_we  = 1'b1;
			res_wd  = '{kind: EV_RESEND, seq: s_cur, handle: rd_s1.handle, len: rd_s1.len};
		end else if (kill && !is_ack) begin
			res_we = 1'b1;
			res_wd = '{kind: EV_DEAD, seq: s_cur, handle: 16'd0, len: 16'd0};
		end else if (tail_push) begin
			res_we      = 1'b1;
			res_wd.kind = is_ack ? EV_DONE : EV_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		rd_s1 <= slot_mem[ptr_q];
		if (res_we) begin
			res_mem[res_n_q[AW-1:0]] <= res_wd;
		end
		res_rd_q <= res_mem[rd_addr];
		if (cmd_fire) begin
			cmd_q <= cmd;
		end
		j_s1   <= j_q;
		ptr_s1 <= ptr_q;
		if (first_surv) begin
			nb_q  <= s_cur;
			nbs_q <= ptr_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			base_q      <= 32'd0;
			base_slot_q <= '0;
			count_q     <= '0;
			j_q         <= '0;
			ptr_q       <= '0;
			act_s1      <= 1'b0;
			last_s1     <= 1'b0;
			found_q     <= 1'b0;
			res_n_q     <= '0;
			rd_idx_q    <= '0;
		end else begin
			act_s1  <= (state_q == S_WALK);
			last_s1 <= (state_q == S_WALK) && (j_q == LAST_IDX);
			if (res_we) begin
				res_n_q <= res_n_q + 1'b1;
			end
			if (kill) begin
				valid_q[ptr_s1] <= 1'b0;
				count_q         <= count_q - 1'b1;
			end
			if (first_surv) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						j_q     <= '0;
						ptr_q   <= base_slot_q;
						found_q <= 1'b0;
						case (cmd.op)
							OP_RECORD: begin
								if (rec_ok) begin
									valid_q[rec_slot] <= 1'b1;
									if (!valid_q[rec_slot]) begin
										count_q <= count_q + 1'b1;
									end
									if (count_q == '0) begin
										base_q <= cmd.seq;
									end
								end
								state_q <= S_PREP;
							end
							OP_QUERY: state_q <= S_PREP;
							default:  state_q <= S_WALK;
						endcase
					end
				end
				S_WALK: begin
					j_q   <= AW'(j_q + 1'b1);
					ptr_q <= (ptr_q == LAST_IDX) ? '0 : AW'(ptr_q + 1'b1);
					if (j_q == LAST_IDX) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					// smallest surviving sequence becomes the new base
					if (first_surv) begin
						base_q      <= s_cur;
						base_slot_q <= ptr_s1;
					end else if (found_q) begin
						base_q      <= nb_q;
						base_slot_q <= nbs_q;
					end
					state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (pop_fire) begin
						if (rd_last) begin
							rd_idx_q <= '0;
							res_n_q  <= '0;
							state_q  <= S_IDLE;
						end else begin
							rd_idx_q <= AW'(rd_idx_q + 1'b1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		out_item.event_kind    = res_rd_q.kind;
		out_item.out_seq       = res_rd_q.seq;
		out_item.out_handle    = res_rd_q.handle;
		out_item.out_len       = res_rd_q.len;
		out_item.pending_count = 6'(count_q);
		out_item.last_flag     = rd_last;
	end

	`RT_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
	`RT_ASSERT_IMP(a_drain_idx, state_q == S_DRAIN,
		(res_n_q != '0) && (CW'(rd_idx_q) < res_n_q), "drain index past results")
	`RT_ASSERT_NXT(a_last_pop, pop_fire && rd_last, state_q == S_IDLE,
		"last beat popped but engine not idle")
	`RT_ASSERT_IMP(a_walk_only, kill || resend, act_s1, "slot update outside walk")

endmodule

// File: rtl/retransmit_tracker.sv
// top level of the retransmit tracker: config registers, front and back
// depends on rt_pkg, rt_front, rt_back
//
// channel   direction  handshake           payload
// input     in         push / full         in_item  (in_item_t)
// result    out        empty / pop         out_item (out_item_t)
// config    in         cfg_we              cfg_idx, cfg_wdata
//
// record and query: the result is written as the item is accepted, and the prep state then opens the drain
// ack and collect: a walk over all DEPTH slots, one table slot per cycle through the slot memory port
// all beats of an item are released together, after its walk ends
// a two-entry input queue keeps taking items while results drain
// reset clears the valid bits at once, so no clearing pass is needed
module retransmit_tracker import rt_pkg::*; #(
	parameter int DEPTH = RT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    in_item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata
);

	logic [31:0] timeout_q;
	logic [7:0]  max_retries_q;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= TIMEOUT_RST;
			max_retries_q <= MAX_RETRIES_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TIMEOUT:     timeout_q     <= cfg_wdata;
				REG_MAX_RETRIES: max_retries_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	rt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	rt_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.timeout_ms  (timeout_q),
		.max_retries (max_retries_q),
		.empty       (empty),
		.pop         (pop),
		.out_item    (out_item)
	);

endmodule

// File: test/tb.sv
// testbench for retransmit_tracker: random and directed record/ack/collect/query beats
// predicts the result beats of every accepted item and checks them in order; depends on rt_pkg
module tb;
	import rt_pkg::*;

	localparam int DEPTH = RT_DEPTH;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_item_t    in_item = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = 1'b0;
	logic [31:0] cfg_wdata = '0;

	retransmit_tracker uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// tracker state as predicted
	logic        tbl_valid [DEPTH];
	logic [31:0] tbl_seq [DEPTH];
	logic [15:0] tbl_handle [DEPTH];
	logic [15:0] tbl_len [DEPTH];
	logic [47:0] tbl_sent [DEPTH];
	logic [7:0]  tbl_retries [DEPTH];
	logic [31:0] win_base;
	int          held;
	logic [31:0] cur_timeout;
	logic [7:0]  cur_max_retries;

	in_item_t  send_q[$];
	out_item_t expected_beats[$];
	int        errors = 0;
	int        cycles = 0;
	bit        calm = 0;      // no idling on either side
	int        rx_hold = 0;   // receiver hold-off, in cycles
	bit        send_pause = 0;
	bit        in_took = 0;   // input beat taken at the last rising edge

	// sequence clock used by the stimulus, kept near the window
	logic [47:0] clock_ms;
	logic [31:0] next_seq;

	function automatic void enqueue(in_item_t it);
		send_q = {send_q, it};
	endfunction

	function automatic void rebase_window();
		logic [31:0] s;
		for (int k = 0; k < DEPTH; k++) begin
			s = win_base + k;
			if (tbl_valid[s % DEPTH] && tbl_seq[s % DEPTH] == s) begin
				win_base = s;
				return;
			end
		end
	endfunction

	function automatic out_item_t beat(event_t k, logic [31:0] s, logic [15:0] h,
			logic [15:0] l);
		out_item_t b;
		b = '0;
		b.event_kind = k;
		b.out_seq = s;
		b.out_handle = h;
		b.out_len = l;
		return b;
	endfunction

	task automatic predict_beats(input in_item_t it);
		out_item_t res[$];
		logic ok;
		int idx;
		logic [31:0] s;
		logic [31:0] base;
		case (op_t'(it.opcode))
			OP_RECORD: begin
				if (held == 0) begin
					win_base = it.seq_num;
					ok = 1;
				end else begin
					ok = it.seq_num >= win_base && (it.seq_num - win_base) < DEPTH;
				end
				if (ok) begin
					idx = it.seq_num % DEPTH;
					if (!tbl_valid[idx]) held++;
					tbl_valid[idx] = 1;
					tbl_seq[idx] = it.seq_num;
					tbl_handle[idx] = it.payload_handle;
					tbl_len[idx] = it.payload_len;
					tbl_sent[idx] = it.now_ms;
					tbl_retries[idx] = 0;
				end
				res = {res, beat(ok ? EV_ACCEPTED : EV_REJECTED, 0, 0, 0)};
			end
			OP_ACK: begin
				for (int i = 0; i < DEPTH; i++)
					if (tbl_valid[i] && tbl_seq[i] <= it.ack_num) begin
						tbl_valid[i] = 0;
						held--;
					end
				rebase_window();
				res = {res, beat(EV_DONE, 0, 0, 0)};
			end
			OP_COLLECT: begin
				base = win_base;
				for (int j = 0; j < DEPTH && held > 0; j++) begin
					s = base + j;
					idx = s % DEPTH;
					if (!tbl_valid[idx] || tbl_seq[idx] != s) continue;
					if (48'(it.now_ms - tbl_sent[idx]) < {16'd0, cur_timeout}) continue;
					if (tbl_retries[idx] >= cur_max_retries) begin
						tbl_valid[idx] = 0;
						held--;
						res = {res, beat(EV_DEAD, s, 0, 0)};
					end else begin
						tbl_sent[idx] = it.now_ms;
						tbl_retries[idx]++;
						res = {res, beat(EV_RESEND, s, tbl_handle[idx], tbl_len[idx])};
					end
				end
				rebase_window();
				if (res.size() == 0) res = {res, beat(EV_NONE, 0, 0, 0)};
			end
			default: res = {res, beat(EV_DONE, 0, 0, 0)};
		endcase
		foreach (res[k]) begin
			res[k].pending_count = 6'(held);
			res[k].last_flag = (k == res.size() - 1);
			expected_beats = {expected_beats, res[k]};
		end
	endtask

	function automatic in_item_t mk(op_t op, logic [31:0] s, logic [15:0] h,
			logic [15:0] l, logic [47:0] t, logic [31:0] a);
		in_item_t it;
		it.opcode = op;
		it.seq_num = s;
		it.payload_handle = h;
		it.payload_len = l;
		it.now_ms = t;
		it.ack_num = a;
		return it;
	endfunction

	function automatic in_item_t rand_item();
		int pick;
		logic [47:0] t;
		pick = $urandom_range(0, 99);
		clock_ms = clock_ms + 48'($urandom_range(0, 40));
		t = clock_ms;
		if (pick < 45)
			return mk(OP_RECORD, 32'(next_seq + $urandom_range(0, 36) - 2),
				16'($urandom), 16'($urandom), t, $urandom);
		else if (pick < 60)
			return mk(OP_ACK, 0, 16'($urandom), 16'($urandom),
				48'({$urandom, $urandom}), 32'(next_seq + $urandom_range(0, 20)));
		else if (pick < 85)
			return mk(OP_COLLECT, $urandom, 16'($urandom), 16'($urandom),
				t + 48'($urandom_range(0, 120)), $urandom);
		else if (pick < 92)
			return mk(OP_QUERY, $urandom, 16'($urandom), 16'($urandom),
				48'({$urandom, $urandom}), $urandom);
		else
			// noise: fully random fields
			return mk(op_t'($urandom_range(0, 3)), $urandom, 16'($urandom),
				16'($urandom), 48'({$urandom, $urandom}), $urandom);
	endfunction

	always @(posedge clk) begin
		in_took <= arst_n && push && !full;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_took) begin
				predict_beats(in_item);
				void'(send_q.pop_front());
			end
			if (!send_pause && send_q.size() > 0 && (calm || $urandom_range(0, 99) >= 29)) begin
				in_item <= send_q[0];
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: random idling, or a counted hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				pop <= 1'b0;
			end else begin
				pop <= calm || $urandom_range(0, 99) >= 29;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		cycles <= cycles + 1;
		if (arst_n && pop && !empty) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, out_item);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				if (out_item !== want) begin
					$display("%0t: mismatch: expected %p actual %p", $time, want, out_item);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		while (send_q.size() > 0 || push || expected_beats.size() > 0) @(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (r == REG_TIMEOUT) cur_timeout = v;
		else cur_max_retries = v[7:0];
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 0;
		win_base = 0;
		held = 0;
		cur_timeout = TIMEOUT_RST;
		cur_max_retries = MAX_RETRIES_RST;
		clock_ms = 48'd5000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset config, extremes, window edges, time wrap
		enqueue(mk(OP_QUERY, '1, '1, '1, '1, '1));
		enqueue(mk(OP_COLLECT, 0, 0, 0, 0, 0));
		enqueue(mk(OP_RECORD, 32'hFFFF_FFE0, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FF00, 0));
		enqueue(mk(OP_RECORD, 32'hFFFF_FFFF, 0, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 0));
		enqueue(mk(OP_RECORD, 32'h0000_0001, 1, 1, 0, 0));
		enqueue(mk(OP_RECORD, 32'hFFFF_FFDF, 2, 2, 0, 0));
		enqueue(mk(OP_COLLECT, 0, 0, 0, 48'd2000, 0));
		enqueue(mk(OP_COLLECT, 0, 0, 0, 48'd2000, 0));
		enqueue(mk(OP_ACK, 0, 0, 0, 0, 32'hFFFF_FFF0));
		enqueue(mk(OP_ACK, 0, 0, 0, 0, '1));
		enqueue(mk(OP_RECORD, 0, 16'h1234, 16'h0, 48'd0, 0));
		enqueue(mk(OP_RECORD, 31, 16'h4321, 16'h8000, 48'd10, 0));
		enqueue(mk(OP_RECORD, 32, 0, 0, 48'd10, 0));
		enqueue(mk(OP_RECORD, 0, 16'hAAAA, 16'h5555, 48'd20, 0));
		enqueue(mk(OP_ACK, 0, 0, 0, 0, 0));
		enqueue(mk(OP_QUERY, 0, 0, 0, 0, 0));
		wait_drained();

		// timeout zero, retries zero: every collect kills
		write_reg(REG_TIMEOUT, 32'd0);
		write_reg(REG_MAX_RETRIES, 32'd0);
		for (int i = 0; i < DEPTH; i++)
			enqueue(mk(OP_RECORD, 32'(100 + i), 16'(i), 16'(i), 48'd0, 0));
		enqueue(mk(OP_COLLECT, 0, 0, 0, 48'd0, 0));
		// receiver holds off while the table fills again
		for (int i = 0; i < DEPTH; i++)
			enqueue(mk(OP_RECORD, 32'(200 + i), 16'(i), 16'(i), 48'd0, 0));
		enqueue(mk(OP_COLLECT, 0, 0, 0, 48'd0, 0));
		rx_hold = 300;
		wait_drained();

		// max values
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(REG_MAX_RETRIES, 32'hFF);
		enqueue(mk(OP_RECORD, 7, 1, 1, 48'd0, 0));
		enqueue(mk(OP_COLLECT, 0, 0, 0, 48'hFFFF_FFFE, 0));
		enqueue(mk(OP_COLLECT, 0, 0, 0, 48'hFFFF_FFFF, 0));
		enqueue(mk(OP_ACK, 0, 0, 0, 0, '1));
		wait_drained();

		// random phases under several settings
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin write_reg(REG_TIMEOUT, 32'd30); write_reg(REG_MAX_RETRIES, 32'd2); end
				1: begin write_reg(REG_TIMEOUT, 32'd60); write_reg(REG_MAX_RETRIES, 32'd0); end
				2: begin write_reg(REG_TIMEOUT, 32'd1); write_reg(REG_MAX_RETRIES, 32'd1); end
				default: begin
					write_reg(REG_TIMEOUT, 32'd1000);
					write_reg(REG_MAX_RETRIES, 32'd5);
				end
			endcase
			next_seq = $urandom;
			calm = (ph == 2);
			for (int n = 0; n < 60; n++) begin
				enqueue(rand_item());
				if ($urandom_range(0, 9) == 0) next_seq = next_seq + $urandom_range(1, 8);
			end
			enqueue(mk(OP_ACK, 0, 0, 0, 0, '1));
			wait_drained();
		end
		calm = 0;
		// sender pause until drained already happened above; one more explicit
		send_pause = 1;
		wait_drained();
		send_pause = 0;

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
